FILE: src/gha_pkg.sv
// Shared types and constants for the generational handle allocator.
// Depends on nothing; used by the top level and the slot memory defaults.
`timescale 1ns / 1ps
`default_nettype none

package gha_pkg;

    localparam int ENTRIES_DEF   = 1024;
    localparam int GEN_BITS_DEF  = 12;
    localparam int SLOT_BITS_DEF = 20;

    localparam int HANDLE_W     = 32;
    localparam int FUNC_W       = 2;
    localparam int COUNT_W      = 11;
    localparam int S_TDATA_W    = 32;
    localparam int M_TDATA_W    = 48;
    localparam int M_TUSER_W    = 1;

    typedef logic [FUNC_W-1:0] func_t;

    localparam func_t FUNC_CREATE  = 2'd0;
    localparam func_t FUNC_DESTROY = 2'd1;
    localparam func_t FUNC_ALIVE   = 2'd2;

endpackage

`default_nettype wire

FILE: src/gha_slot_mem.sv
// Slot table: one synchronous memory holding used mark, generation and
// free-list link per slot. One write and one registered read per cycle.
`timescale 1ns / 1ps
`default_nettype none

module gha_slot_mem #(
    parameter int DEPTH = gha_pkg::ENTRIES_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int WIDTH = 1
) (
    input  wire              aclk,
    input  wire              rd_en,
    input  wire  [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  wire              wr_en,
    input  wire  [AW-1:0]    wr_addr,
    input  wire  [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/generational_handle_allocator_unit.sv
// Generational handle allocator: create, destroy and alive requests.
// Each request reads its slot entry when accepted, then modifies and writes it back.
// A new request is taken only once the last one has left ST_EXEC (read-modify-write).
// A result waiting in the output register does not block the next accept.
// Reset: control, free-list head, live count and fill mark clear synchronously; the
// slot memory is not swept, slots at or above the fill mark read as fresh.
`timescale 1ns / 1ps
`default_nettype none

module generational_handle_allocator_unit #(
    parameter int ENTRIES   = gha_pkg::ENTRIES_DEF,
    parameter int GEN_BITS  = gha_pkg::GEN_BITS_DEF,
    parameter int SLOT_BITS = gha_pkg::SLOT_BITS_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             cfg_we,
    input  wire                             cfg_wdata,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [gha_pkg::S_TDATA_W-1:0]   s_tdata,   // [31:0] handle
    input  wire  [gha_pkg::FUNC_W-1:0]      s_tuser,   // [1:0] func
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [gha_pkg::M_TDATA_W-1:0]   m_tdata,   // [31:0] new_handle, [42:32] live_count
    output logic [gha_pkg::M_TUSER_W-1:0]   m_tuser    // [0] ok
);

    localparam int IDX_W = $clog2(ENTRIES + 1);
    localparam int AW    = $clog2(ENTRIES);
    localparam int ENT_W = 1 + GEN_BITS + IDX_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                 state_reg, state_next;
    logic                 enabled_reg;
    logic [IDX_W-1:0]     free_head_reg, free_head_next;
    logic [IDX_W-1:0]     cnt_reg, cnt_next;
    logic [IDX_W-1:0]     fill_reg, fill_next;
    gha_pkg::func_t       op_reg;
    logic [IDX_W-1:0]     slot_reg;
    logic [GEN_BITS-1:0]  gen_reg;
    logic                 range_ok_reg;

    logic                          m_valid_reg, m_valid_next;
    logic [gha_pkg::HANDLE_W-1:0]  out_handle_reg, out_handle_next;
    logic                          out_ok_reg, out_ok_next;

    logic                  accept;
    logic                  fire;
    logic [SLOT_BITS-1:0]  in_field;
    logic                  in_range_ok;
    logic [IDX_W-1:0]      in_slot;
    logic [IDX_W-1:0]      rd_idx;

    logic [ENT_W-1:0]      rd_data;
    logic                  wr_en;
    logic [ENT_W-1:0]      wr_data;

    logic                  fresh;
    logic                  ent_used;
    logic [GEN_BITS-1:0]   ent_gen;
    logic [IDX_W-1:0]      ent_next;
    logic [IDX_W-1:0]      slot_p1;
    logic [GEN_BITS-1:0]   gen_inc;
    logic                  live;

    assign accept = s_tvalid && s_tready;
    assign fire   = (state_reg == ST_EXEC) && (!m_valid_reg || m_tready);

    assign in_field    = s_tdata[SLOT_BITS-1:0];
    assign in_range_ok = (in_field != '0) && (in_field <= SLOT_BITS'(ENTRIES));
    assign in_slot     = IDX_W'(in_field - SLOT_BITS'(1));
    assign rd_idx      = (gha_pkg::func_t'(s_tuser) == gha_pkg::FUNC_CREATE) ?
                         free_head_reg : in_slot;

    gha_slot_mem #(
        .DEPTH (ENTRIES),
        .AW    (AW),
        .WIDTH (ENT_W)
    ) u_slot_mem (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (rd_idx[AW-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (slot_reg[AW-1:0]),
        .wr_data (wr_data)
    );

    // Slots at or above the fill mark were never written: read them as fresh.
    assign slot_p1  = slot_reg + IDX_W'(1);
    assign fresh    = (slot_reg >= fill_reg);
    assign ent_used = fresh ? 1'b0 : rd_data[ENT_W-1];
    assign ent_gen  = fresh ? '0 : rd_data[IDX_W +: GEN_BITS];
    assign ent_next = fresh ? slot_p1 : rd_data[IDX_W-1:0];
    assign gen_inc  = ent_gen + GEN_BITS'(1);
    assign live     = range_ok_reg && ent_used && (ent_gen == gen_reg);

    always_comb begin
        state_next      = state_reg;
        free_head_next  = free_head_reg;
        cnt_next        = cnt_reg;
        fill_next       = fill_reg;
        m_valid_next    = m_valid_reg;
        out_handle_next = out_handle_reg;
        out_ok_next     = out_ok_reg;
        wr_en           = 1'b0;
        wr_data         = {1'b0, gen_inc, ent_next};

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (fire) begin
                    state_next      = ST_IDLE;
                    m_valid_next    = 1'b1;
                    out_handle_next = '0;
                    out_ok_next     = 1'b0;
                    case (op_reg)
                        gha_pkg::FUNC_CREATE: begin
                            if (enabled_reg && (cnt_reg < IDX_W'(ENTRIES)) &&
                                (slot_reg < IDX_W'(ENTRIES))) begin
                                wr_en          = 1'b1;
                                wr_data        = {1'b1, gen_inc, ent_next};
                                free_head_next = ent_next;
                                cnt_next       = cnt_reg + IDX_W'(1);
                                if (slot_reg == fill_reg) begin
                                    fill_next = fill_reg + IDX_W'(1);
                                end
                                out_handle_next[SLOT_BITS +: GEN_BITS] = gen_inc;
                                out_handle_next[SLOT_BITS-1:0] = SLOT_BITS'(slot_p1);
                                out_ok_next = 1'b1;
                            end
                        end
                        gha_pkg::FUNC_DESTROY: begin
                            if (enabled_reg && live) begin
                                wr_en          = 1'b1;
                                wr_data        = {1'b0, gen_inc, free_head_reg};
                                free_head_next = slot_reg;
                                if (cnt_reg != '0) begin
                                    cnt_next = cnt_reg - IDX_W'(1);
                                end
                                out_ok_next = 1'b1;
                            end
                        end
                        gha_pkg::FUNC_ALIVE: begin
                            out_ok_next = live;
                        end
                        default: begin
                            out_ok_next = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            enabled_reg   <= 1'b0;
            free_head_reg <= '0;
            cnt_reg       <= '0;
            fill_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            cnt_reg       <= cnt_next;
            fill_reg      <= fill_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we) begin
                enabled_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_handle_reg <= out_handle_next;
        out_ok_reg     <= out_ok_next;
        if (accept) begin
            op_reg       <= gha_pkg::func_t'(s_tuser);
            slot_reg     <= rd_idx;
            gen_reg      <= s_tdata[SLOT_BITS +: GEN_BITS];
            range_ok_reg <= in_range_ok;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(gha_pkg::M_TDATA_W - gha_pkg::COUNT_W - gha_pkg::HANDLE_W)'(0),
                       gha_pkg::COUNT_W'(cnt_reg), out_handle_reg};
    assign m_tuser  = out_ok_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= IDX_W'(ENTRIES))
        else $error("live count above pool size");

    a_head_below_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        free_head_reg <= fill_reg)
        else $error("free-list head beyond fill mark");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (m_tvalid && ((cnt_reg == $past(cnt_reg)) ||
                               (cnt_reg == $past(cnt_reg) + IDX_W'(1)) ||
                               (cnt_reg == $past(cnt_reg) - IDX_W'(1)))))
        else $error("result missing or count jumped");

    a_create_handle: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && out_ok_next && (op_reg == gha_pkg::FUNC_CREATE)) |=>
            (m_tdata[SLOT_BITS-1:0] != '0))
        else $error("created handle has empty slot field");
`endif

endmodule

`default_nettype wire

FILE: tb/generational_handle_allocator_unit_tb.sv
// Self-checking bench for generational_handle_allocator_unit: a handle pool tracker
// predicts each result from the accepted requests and checks the result stream in order.
// Depends on gha_pkg and the allocator top level only.
`timescale 1ns / 1ps

module generational_handle_allocator_unit_tb;

    localparam int ENTRIES     = gha_pkg::ENTRIES_DEF;
    localparam int GEN_BITS    = gha_pkg::GEN_BITS_DEF;
    localparam int SLOT_BITS   = gha_pkg::SLOT_BITS_DEF;
    localparam int HANDLE_W    = gha_pkg::HANDLE_W;
    localparam int COUNT_W     = gha_pkg::COUNT_W;
    localparam int FUNC_W      = gha_pkg::FUNC_W;
    localparam int S_TDATA_W   = gha_pkg::S_TDATA_W;
    localparam int M_TDATA_W   = gha_pkg::M_TDATA_W;
    localparam int M_TUSER_W   = gha_pkg::M_TUSER_W;
    localparam int GEN_MAX     = (1 << GEN_BITS) - 1;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int DEAD_KEEP   = 64;

    localparam gha_pkg::func_t FUNC_UNUSED = 2'd3;

    typedef struct {
        logic [HANDLE_W-1:0] new_handle;
        logic                ok;
        logic [COUNT_W-1:0]  live_count;
    } alloc_result_t;

    class handle_pool_tracker;
        bit                  used [ENTRIES];
        logic [GEN_BITS-1:0] gen [ENTRIES];
        int unsigned         next_free [ENTRIES];
        int unsigned         free_head;
        int unsigned         used_count;
        bit                  enabled;
        alloc_result_t       due_results[$];
        logic [HANDLE_W-1:0] live_handles[$];
        logic [HANDLE_W-1:0] dead_handles[$];
        logic [HANDLE_W-1:0] last_created;
        int                  errors;

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                used[i]      = 1'b0;
                gen[i]       = '0;
                next_free[i] = i + 1;
            end
            free_head    = 0;
            used_count   = 0;
            enabled      = 1'b0;
            last_created = '0;
            errors       = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function bit lookup(input logic [HANDLE_W-1:0] h, output int unsigned slot);
            int unsigned field;
            field = h & ((1 << SLOT_BITS) - 1);
            slot  = 0;
            if (field == 0 || field > ENTRIES) return 1'b0;
            slot = field - 1;
            if (!used[slot]) return 1'b0;
            return gen[slot] == h[SLOT_BITS +: GEN_BITS];
        endfunction

        function void drop_live(input logic [HANDLE_W-1:0] h);
            for (int i = 0; i < live_handles.size(); i++) begin
                if (live_handles[i] == h) begin
                    live_handles.delete(i);
                    break;
                end
            end
            dead_handles.insert(dead_handles.size(), h);
            if (dead_handles.size() > DEAD_KEEP) void'(dead_handles.pop_front());
        endfunction

        function void note_request(input gha_pkg::func_t f, input logic [HANDLE_W-1:0] h);
            alloc_result_t r;
            int unsigned   slot;
            r.new_handle = '0;
            r.ok         = 1'b0;
            case (f)
                gha_pkg::FUNC_CREATE: begin
                    if (enabled && used_count < ENTRIES && free_head < ENTRIES) begin
                        slot       = free_head;
                        free_head  = next_free[slot];
                        used[slot] = 1'b1;
                        gen[slot]  = gen[slot] + 1'b1;
                        used_count++;
                        r.new_handle = (HANDLE_W'(gen[slot]) << SLOT_BITS) | HANDLE_W'(slot + 1);
                        r.ok         = 1'b1;
                        last_created = r.new_handle;
                        live_handles.insert(live_handles.size(), r.new_handle);
                    end
                end
                gha_pkg::FUNC_DESTROY: begin
                    if (enabled && lookup(h, slot)) begin
                        used[slot]      = 1'b0;
                        gen[slot]       = gen[slot] + 1'b1;
                        next_free[slot] = free_head;
                        free_head       = slot;
                        if (used_count > 0) used_count--;
                        r.ok = 1'b1;
                        drop_live(h);
                    end
                end
                gha_pkg::FUNC_ALIVE: r.ok = lookup(h, slot);
                default: ;
            endcase
            r.live_count = COUNT_W'(used_count);
            due_results.insert(due_results.size(), r);
        endfunction

        function void check_result(input logic [HANDLE_W-1:0] nh, input logic ok,
                                   input logic [COUNT_W-1:0] live);
            alloc_result_t e;
            if (due_results.size() == 0) begin
                $error("unexpected result: new_handle %h ok %0b live_count %0d", nh, ok, live);
                errors++;
                return;
            end
            e = due_results.pop_front();
            if (nh !== e.new_handle) begin
                $error("new_handle: expected %h, actual %h", e.new_handle, nh);
                errors++;
            end
            if (ok !== e.ok) begin
                $error("ok: expected %0b, actual %0b", e.ok, ok);
                errors++;
            end
            if (live !== e.live_count) begin
                $error("live_count: expected %0d, actual %0d", e.live_count, live);
                errors++;
            end
        endfunction

        function logic [HANDLE_W-1:0] stray_handle();
            logic [HANDLE_W-1:0] h;
            case ($urandom_range(0, 3))
                0: h = $urandom;
                1: h = (dead_handles.size() != 0) ?
                       dead_handles[$urandom_range(0, dead_handles.size() - 1)] : $urandom;
                2: h = (HANDLE_W'($urandom_range(0, GEN_MAX)) << SLOT_BITS) |
                       HANDLE_W'($urandom_range(1, ENTRIES));
                default: h = (live_handles.size() != 0) ?
                       live_handles[$urandom_range(0, live_handles.size() - 1)] ^
                       (HANDLE_W'($urandom_range(1, GEN_MAX)) << SLOT_BITS) : $urandom;
            endcase
            return h;
        endfunction

        function logic [HANDLE_W-1:0] pick_live();
            if (live_handles.size() == 0) return stray_handle();
            return live_handles[$urandom_range(0, live_handles.size() - 1)];
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_wdata = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;  // [31:0] handle
    logic [FUNC_W-1:0]    s_tuser   = '0;  // [1:0] func
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // [31:0] new_handle, [42:32] live_count
    logic [M_TUSER_W-1:0] m_tuser;         // [0] ok

    handle_pool_tracker pool = new();
    bit idle_on      = 1'b1;
    bit hold_request = 1'b0;
    int stall_cycles = 0;

    generational_handle_allocator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_request(input gha_pkg::func_t f, input logic [HANDLE_W-1:0] h);
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= h;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pool.note_request(f, h);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pool.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_enabled(input bit value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        pool.enabled = value;
    endtask

    task automatic random_requests(input int n, input int create_pct);
        int pick;
        repeat (n) begin
            if ($urandom_range(0, 99) < create_pct) begin
                send_request(gha_pkg::FUNC_CREATE, $urandom);
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 5)       send_request(gha_pkg::FUNC_DESTROY, pool.pick_live());
                else if (pick == 5) send_request(gha_pkg::FUNC_DESTROY, pool.stray_handle());
                else if (pick < 8)  send_request(gha_pkg::FUNC_ALIVE, pool.pick_live());
                else if (pick == 8) send_request(gha_pkg::FUNC_ALIVE, pool.stray_handle());
                else                send_request(FUNC_UNUSED, $urandom);
            end
        end
    endtask

    initial begin
        int gap;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            gap = idle_on ? $urandom_range(0, 11) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            pool.check_result(m_tdata[31:0], m_tuser[0], m_tdata[42:32]);
        end
    end

    initial begin
        logic [HANDLE_W-1:0] h1;
        logic [HANDLE_W-1:0] h2;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // disabled pool after reset
        write_enabled(1'b0);
        send_request(gha_pkg::FUNC_CREATE, 32'hFFFF_FFFF);
        send_request(gha_pkg::FUNC_DESTROY, 32'h0010_0001);
        send_request(gha_pkg::FUNC_ALIVE, 32'h0010_0001);
        send_request(gha_pkg::FUNC_ALIVE, 32'h0000_0000);
        send_request(FUNC_UNUSED, 32'hFFFF_FFFF);
        wait_for_results();

        write_enabled(1'b1);
        send_request(gha_pkg::FUNC_CREATE, 32'h0000_0000);
        h1 = pool.last_created;
        send_request(gha_pkg::FUNC_CREATE, 32'h0000_0000);
        h2 = pool.last_created;
        send_request(gha_pkg::FUNC_CREATE, 32'hFFFF_FFFF);
        send_request(gha_pkg::FUNC_ALIVE, h1);
        send_request(gha_pkg::FUNC_ALIVE, h1 ^ (32'h1 << SLOT_BITS));
        send_request(gha_pkg::FUNC_DESTROY, h2);
        send_request(gha_pkg::FUNC_DESTROY, h2);
        send_request(gha_pkg::FUNC_ALIVE, h2);
        send_request(gha_pkg::FUNC_CREATE, 32'h0000_0000);
        send_request(gha_pkg::FUNC_ALIVE, 32'h0000_0000);
        send_request(gha_pkg::FUNC_ALIVE, 32'hFFF0_0000);
        send_request(gha_pkg::FUNC_ALIVE, 32'h0000_0401);
        send_request(gha_pkg::FUNC_DESTROY, 32'h0000_0401);
        send_request(gha_pkg::FUNC_ALIVE, 32'h0000_0400);
        send_request(gha_pkg::FUNC_DESTROY, 32'hFFFF_FFFF);
        send_request(FUNC_UNUSED, pool.last_created);
        send_request(gha_pkg::FUNC_ALIVE, pool.last_created);
        wait_for_results();

        // disabled with live slots: alive still answers
        write_enabled(1'b0);
        send_request(gha_pkg::FUNC_DESTROY, h1);
        send_request(gha_pkg::FUNC_CREATE, 32'h0000_0000);
        send_request(gha_pkg::FUNC_ALIVE, h1);
        wait_for_results();

        write_enabled(1'b1);
        hold_request = 1'b1;
        random_requests(400, 55);
        wait_for_results();

        idle_on = 1'b0;
        random_requests(100, 55);
        idle_on = 1'b1;
        wait_for_results();

        write_enabled(1'b0);
        send_request(gha_pkg::FUNC_CREATE, $urandom);
        send_request(gha_pkg::FUNC_DESTROY, pool.pick_live());
        wait_for_results();

        write_enabled(1'b1);
        random_requests(340, 30);
        repeat (20) send_request(gha_pkg::FUNC_DESTROY, pool.pick_live());

        wait_for_results();
        repeat (10) @(posedge aclk);
        if (pool.errors == 0 && pool.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
